[hdl/lzd_pkg.sv]
// Shared constants and types for the LZ77 bit-stream decoder.
`default_nettype none
package lzd_pkg;

  // Sizing of the stream format and history window (window depth is a power of two).
  localparam int WINDOW_DEPTH = 2048;
  localparam int OFFSET_WIDTH = 11;
  localparam int LENGTH_WIDTH = 5;
  localparam int BLOCK_BYTES  = 256;

  localparam int BYTE_W       = 8;
  localparam int COUNT_W      = 16;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int MATCH_BITS   = 1 + OFFSET_WIDTH + LENGTH_WIDTH;
  localparam int LITERAL_BITS = 1 + BYTE_W;
  // Pending bits never exceed MATCH_BITS-1 before a byte is appended.
  localparam int ACC_W        = MATCH_BITS - 1 + BYTE_W;
  localparam int BITCNT_W     = $clog2(ACC_W + 1);
  localparam int POS_W        = $clog2(BLOCK_BYTES + 1);
  localparam int REM_W        = POS_W + 4;

  localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;
  localparam logic [COUNT_W-1:0]      COUNT_MAX  = '1;

  // One decoded token, valid in the cycle its last input byte is accepted.
  typedef struct packed {
    logic                    valid;
    logic                    is_lit;
    logic [BYTE_W-1:0]       lit;
    logic [OFFSET_WIDTH-1:0] offset;
    logic [LENGTH_WIDTH-1:0] len;
  } token_t;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               run_last;
    logic [COUNT_W-1:0] max_match_count;
  } out_word_t;

endpackage
`default_nettype wire

[hdl/lzd_if.sv]
// Valid/ready channel interfaces for compressed input and decoded output words.
`default_nettype none
interface lzd_in_if;
  logic                      valid;
  logic                      ready;
  logic [lzd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzd_out_if;
  logic                       valid;
  logic                       ready;
  logic [lzd_pkg::BYTE_W-1:0]  out_byte;
  logic                       run_last;
  logic [lzd_pkg::COUNT_W-1:0] max_match_count;

  modport source (output valid, output out_byte, output run_last,
                  output max_match_count, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input max_match_count, output ready);
endinterface
`default_nettype wire

[hdl/lzd_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hdl/lzd_unpack.sv]
// Bit accumulator, block tail skipping and token extraction.
`default_nettype none
module lzd_unpack (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [lzd_pkg::BYTE_W-1:0] in_byte,
  output lzd_pkg::token_t                 token
);

  logic [lzd_pkg::ACC_W-1:0]    acc, acc_next;
  logic [lzd_pkg::BITCNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [lzd_pkg::POS_W-1:0]    pos, pos_next;

  logic [lzd_pkg::ACC_W-1:0]    acc_base, acc_app, flag_sh, lit_sh, match_sh;
  logic [lzd_pkg::BITCNT_W-1:0] cnt_base, cnt_app, need;
  logic [lzd_pkg::POS_W-1:0]    pos_base;
  logic [lzd_pkg::REM_W-1:0]    remain;
  logic                         skip, flag, complete;

  // Block boundary handling, byte append and field extraction.
  always_comb begin
    acc_base = acc;
    cnt_base = bit_cnt;
    pos_base = pos;
    skip     = 1'b0;
    remain   = ((lzd_pkg::REM_W'(lzd_pkg::BLOCK_BYTES) - lzd_pkg::REM_W'(pos)) << 3)
               + lzd_pkg::REM_W'(bit_cnt);
    if (pos >= lzd_pkg::POS_W'(lzd_pkg::BLOCK_BYTES)) begin
      acc_base = '0;
      cnt_base = '0;
      pos_base = '0;
    end else if (remain < lzd_pkg::REM_W'(lzd_pkg::MATCH_BITS)) begin
      skip = 1'b1;
    end

    acc_app  = {acc_base[lzd_pkg::ACC_W-lzd_pkg::BYTE_W-1:0], in_byte};
    cnt_app  = cnt_base + lzd_pkg::BITCNT_W'(lzd_pkg::BYTE_W);
    flag_sh  = acc_app >> (cnt_app - lzd_pkg::BITCNT_W'(1));
    flag     = flag_sh[0];
    need     = flag ? lzd_pkg::BITCNT_W'(lzd_pkg::LITERAL_BITS)
                    : lzd_pkg::BITCNT_W'(lzd_pkg::MATCH_BITS);
    lit_sh   = acc_app >> (cnt_app - lzd_pkg::BITCNT_W'(lzd_pkg::LITERAL_BITS));
    match_sh = acc_app >> (cnt_app - lzd_pkg::BITCNT_W'(lzd_pkg::MATCH_BITS));
    complete = !skip && (cnt_app >= need);

    token.valid  = accept && complete;
    token.is_lit = flag;
    token.lit    = lit_sh[lzd_pkg::BYTE_W-1:0];
    token.len    = match_sh[lzd_pkg::LENGTH_WIDTH-1:0];
    token.offset = match_sh[lzd_pkg::LENGTH_WIDTH +: lzd_pkg::OFFSET_WIDTH];

    acc_next     = acc;
    bit_cnt_next = bit_cnt;
    pos_next     = pos;
    if (accept) begin
      if (skip) begin
        acc_next     = '0;
        bit_cnt_next = '0;
        pos_next     = pos + lzd_pkg::POS_W'(1);
      end else begin
        acc_next     = acc_app;
        bit_cnt_next = complete ? cnt_app - need : cnt_app;
        pos_next     = pos_base + lzd_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      bit_cnt <= '0;
      pos     <= '0;
    end else begin
      acc     <= acc_next;
      bit_cnt <= bit_cnt_next;
      pos     <= pos_next;
    end
  end

endmodule
`default_nettype wire

[hdl/lzd_out_buf.sv]
// Two-entry output buffer that decouples decoding from the output handshake.
`default_nettype none
module lzd_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire lzd_pkg::out_word_t push_word,
  output logic                    space,
  lzd_out_if.source               out_ch
);

  lzd_pkg::out_word_t entry [2];
  logic [1:0] count;
  logic       wr_sel, rd_sel;
  logic       pop;

  assign pop                    = out_ch.valid && out_ch.ready;
  assign space                  = (count != 2'd2);
  assign out_ch.valid           = (count != 2'd0);
  assign out_ch.out_byte        = entry[rd_sel].out_byte;
  assign out_ch.run_last        = entry[rd_sel].run_last;
  assign out_ch.max_match_count = entry[rd_sel].max_match_count;

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_sel] <= push_word;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
    end else begin
      if (push) begin
        wr_sel <= !wr_sel;
      end
      if (pop) begin
        rd_sel <= !rd_sel;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/lz77_bitstream_decoder_top.sv]
// Top level of the LZ77 bit-stream decoder: copy sequencer around the history window.
//
// Compressed bytes enter one word at a time, most significant bit first, and each
// decoded byte leaves as one output word. A byte that completes no token, or that
// completes a literal, is handled entirely in the idle state. A byte that completes
// a match holds off further input until the copy ends: every copied byte is first
// read from the history RAM and then written back and emitted, through the single
// read and single write port of the window memory. A two-word output buffer lets
// input be accepted while results wait. No clearing pass follows reset: the write
// pointer and a wrapped flag act as a fill count, and window entries not yet written
// read as zero.
`default_nettype none
module lz77_bitstream_decoder_top (
  input  wire logic  clk,
  input  wire logic  rst,
  lzd_in_if.sink     in_ch,
  lzd_out_if.source  out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0] state, state_next;
  logic [lzd_pkg::ADDR_W-1:0]       wp, wp_next, rp, rp_next, start, start_next;
  logic [lzd_pkg::ADDR_W-1:0]       rp_eff;
  logic [lzd_pkg::LENGTH_WIDTH-1:0] left, left_next;
  logic [lzd_pkg::COUNT_W-1:0]      mcount, mcount_next;
  logic                             wrapped, wrapped_next, first, first_next;
  logic                             rd_ok, rd_ok_next;

  logic                       accept, space, push;
  lzd_pkg::out_word_t         push_word;
  lzd_pkg::token_t            token;
  logic                       ram_we, ram_re;
  logic [lzd_pkg::BYTE_W-1:0] ram_wd, ram_rd;

  assign in_ch.ready = (state == ST_IDLE) && space;
  assign accept      = in_ch.valid && in_ch.ready;

  lzd_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .token   (token)
  );

  lzd_ram #(
    .WIDTH (lzd_pkg::BYTE_W),
    .DEPTH (lzd_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (rp_eff),
    .rd_data (ram_rd)
  );

  lzd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .space     (space),
    .out_ch    (out_ch)
  );

  // Token handling and the read-then-write copy sequence.
  always_comb begin
    state_next   = state;
    wp_next      = wp;
    rp_next      = rp;
    start_next   = start;
    left_next    = left;
    mcount_next  = mcount;
    wrapped_next = wrapped;
    first_next   = first;
    rd_ok_next   = rd_ok;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wd       = token.lit;
    push         = 1'b0;
    push_word    = '{out_byte: token.lit, run_last: 1'b1, max_match_count: mcount};
    // The copy returns to its start when it catches up with the write pointer.
    rp_eff       = (!first && (rp == wp)) ? start : rp;

    case (state)
      ST_IDLE: begin
        if (token.valid) begin
          if (token.is_lit) begin
            ram_we  = 1'b1;
            push    = 1'b1;
            wp_next = wp + lzd_pkg::ADDR_W'(1);
            if (wp == '1) begin
              wrapped_next = 1'b1;
            end
          end else begin
            if (token.len == lzd_pkg::LENGTH_MAX && mcount != lzd_pkg::COUNT_MAX) begin
              mcount_next = mcount + lzd_pkg::COUNT_W'(1);
            end
            start_next = wp - lzd_pkg::ADDR_W'(token.offset);
            rp_next    = wp - lzd_pkg::ADDR_W'(token.offset);
            left_next  = token.len;
            first_next = 1'b1;
            state_next = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_re     = 1'b1;
        rd_ok_next = wrapped || (rp_eff < wp);
        rp_next    = rp_eff + lzd_pkg::ADDR_W'(1);
        first_next = 1'b0;
        state_next = ST_WR;
      end
      ST_WR: begin
        ram_wd    = rd_ok ? ram_rd : '0;
        push_word = '{out_byte: ram_wd, run_last: (left == '0), max_match_count: mcount};
        if (space) begin
          ram_we  = 1'b1;
          push    = 1'b1;
          wp_next = wp + lzd_pkg::ADDR_W'(1);
          if (wp == '1) begin
            wrapped_next = 1'b1;
          end
          if (left == '0) begin
            state_next = ST_IDLE;
          end else begin
            left_next  = left - lzd_pkg::LENGTH_WIDTH'(1);
            state_next = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wp      <= '0;
      wrapped <= 1'b0;
      mcount  <= '0;
      first   <= 1'b0;
    end else begin
      state   <= state_next;
      wp      <= wp_next;
      wrapped <= wrapped_next;
      mcount  <= mcount_next;
      first   <= first_next;
    end
  end

  // Copy bookkeeping.
  always_ff @(posedge clk) begin
    rp    <= rp_next;
    start <= start_next;
    left  <= left_next;
    rd_ok <= rd_ok_next;
  end

endmodule
`default_nettype wire
